// ===== hw/rtl/vbdda_pkg.sv =====
// ============================================================================
// vbdda_pkg: shared types and constants for the voxel brick DDA traversal
// Holds the brick geometry, the fixed-point constants, the action codes, the
// controller states and the command and status structs.
// ============================================================================
package vbdda_pkg;

    localparam int BRICK_SIDE  = 8;
    localparam int CELL_W      = $clog2(BRICK_SIDE);
    localparam int VOX_COUNT   = BRICK_SIDE * BRICK_SIDE * BRICK_SIDE;
    localparam int ADDR_W      = $clog2(VOX_COUNT);
    localparam int STEP_LIMIT  = 256;
    localparam int STEP_W      = 9;
    localparam int TMAX_W      = 52;
    localparam logic [7:0]  SHADOW_SOLID_MIN = 8'd16;
    localparam logic [15:0] ABSORB_THRESHOLD = 16'd55705;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_TRACE  = 2'd1,
        ACT_SHADOW = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_TEST,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic setup;
        logic read_voxel;
        logic test_voxel;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic budget_done;
        logic stop;
        logic exited_brick;
    } status_t;

endpackage

// ===== hw/rtl/vbdda_ram.sv =====
// ============================================================================
// vbdda_ram: generic single-port RAM
// One write and one read per cycle at the same address, with registered read data.
// ============================================================================
module vbdda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

// ===== hw/rtl/vbdda_ctrl.sv =====
// ============================================================================
// vbdda_ctrl: traversal controller
// Sequences load, setup, and the read, test and step phases of each DDA step.
// ============================================================================
module vbdda_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_fire,
    input  vbdda_pkg::action_t  s_action,
    input  logic                m_free,
    input  vbdda_pkg::status_t  status,
    output vbdda_pkg::cmd_t     cmd,
    output logic                s_ready
);
    import vbdda_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_action == ACT_TRACE || s_action == ACT_SHADOW)) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_READ;
            ST_READ: begin
                if (status.budget_done) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.stop) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (status.exited_brick) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (m_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load_item = s_fire && (s_action == ACT_LOAD);
                cmd.setup = s_fire;
            end
            ST_READ: cmd.read_voxel = 1'b1;
            ST_TEST: cmd.test_voxel = 1'b1;
            ST_STEP: cmd.step = 1'b1;
            ST_DONE: cmd.finish = m_free;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/vbdda_dp.sv =====
// ============================================================================
// vbdda_dp: traversal datapath
// Holds the ray state, the brick memory port, the per-step compare logic and
// the result register.
// ============================================================================
module vbdda_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vbdda_pkg::cmd_t                cmd,
    output vbdda_pkg::status_t             status,
    input  logic [1:0]                     s_action,
    input  logic [7:0]                     s_voxel_value,
    input  logic [18:0]                    s_entry_x,
    input  logic [18:0]                    s_entry_y,
    input  logic [18:0]                    s_entry_z,
    input  logic signed [31:0]             s_recip_dir_x,
    input  logic signed [31:0]             s_recip_dir_y,
    input  logic signed [31:0]             s_recip_dir_z,
    input  logic [7:0]                     s_medium_material,
    input  logic [7:0]                     s_ignored_material,
    input  logic [15:0]                    s_random_draw,
    input  logic [8:0]                     s_steps_before,
    input  logic                           m_ready_in,
    output logic                           m_valid,
    output logic [51:0]                    m_data
);
    import vbdda_pkg::*;

    logic [ADDR_W-1:0] load_ptr_reg;
    logic [CELL_W-1:0] cell_reg [3];
    logic              neg_reg [3];
    logic signed [TMAX_W-1:0] tmax_reg [3];
    logic [31:0]       delta_reg [3];
    logic signed [TMAX_W-1:0] t_reg;
    logic [1:0]        axis_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [7:0]        medium_reg, ignored_reg;
    logic              shadow_reg, absorb_reg, passed_reg, hit_reg, out_valid_reg;
    logic [7:0]        material_reg;
    logic [51:0]       out_data_reg;

    logic [18:0]       entry [3];
    logic signed [31:0] recip [3];
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        vox;
    logic              stop_now;
    logic [1:0]        ax;
    logic              at_edge;
    logic [31:0]       dist_val;

    assign entry[0] = s_entry_x;
    assign entry[1] = s_entry_y;
    assign entry[2] = s_entry_z;
    assign recip[0] = s_recip_dir_x;
    assign recip[1] = s_recip_dir_y;
    assign recip[2] = s_recip_dir_z;

    assign ram_addr = cmd.load_item ? load_ptr_reg
                    : ADDR_W'({cell_reg[2], cell_reg[1], cell_reg[0]});

    vbdda_ram #(.WIDTH(8), .DEPTH(VOX_COUNT)) u_brick (
        .aclk  (aclk),
        .we    (cmd.load_item),
        .addr  (ram_addr),
        .wdata (s_voxel_value),
        .rdata (vox)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg <= '0;
        end else if (cmd.load_item) begin
            load_ptr_reg <= load_ptr_reg + 1'b1;
        end
    end

    // Setup: each axis gets one 21x32 signed multiply, truncated toward zero.
    always_ff @(posedge aclk) begin
        logic [2:0]          ci;
        logic [CELL_W-1:0]   c;
        logic signed [20:0]  frac;
        logic signed [52:0]  prod;
        logic [52:0]         mag;
        logic [36:0]         q;
        if (cmd.setup) begin
            for (int i = 0; i < 3; i++) begin
                ci = entry[i][18:16];
                c = CELL_W'(ci);
                frac = $signed({2'b0, c, 16'b0}) - $signed({2'b0, entry[i]})
                     + (recip[i][31] ? 21'sd0 : 21'sd65536);
                prod = 53'(frac) * 53'(recip[i]);
                mag = prod[52] ? -prod : prod;
                q = mag[52:16];
                cell_reg[i]  <= c;
                neg_reg[i]   <= recip[i][31];
                delta_reg[i] <= recip[i][31] ? 32'(-recip[i]) : 32'(recip[i]);
                tmax_reg[i]  <= prod[52] ? -TMAX_W'($signed({1'b0, q}))
                                         : TMAX_W'($signed({1'b0, q}));
            end
            medium_reg  <= s_medium_material;
            ignored_reg <= s_ignored_material;
            shadow_reg  <= (s_action == ACT_SHADOW);
            absorb_reg  <= (s_random_draw > ABSORB_THRESHOLD);
            steps_reg   <= s_steps_before;
            passed_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            material_reg <= '0;
            axis_reg    <= '0;
            t_reg       <= '0;
        end else if (cmd.test_voxel) begin
            if (stop_now) begin
                hit_reg <= 1'b1;
                material_reg <= vox;
            end else if (medium_reg == 8'd0 && vox == 8'd0 && ignored_reg != 8'd0) begin
                passed_reg <= 1'b1;
            end
        end else if (cmd.step && !at_edge) begin
            cell_reg[ax] <= neg_reg[ax] ? cell_reg[ax] - 1'b1 : cell_reg[ax] + 1'b1;
            axis_reg <= ax;
            t_reg <= tmax_reg[ax];
            tmax_reg[ax] <= tmax_reg[ax] + TMAX_W'(delta_reg[ax]);
            steps_reg <= steps_reg + 1'b1;
        end
    end

    always_comb begin
        stop_now = 1'b0;
        if (medium_reg != 8'd0) begin
            stop_now = (vox != medium_reg);
        end else if (vox != 8'd0) begin
            if (shadow_reg) begin
                stop_now = (vox > SHADOW_SOLID_MIN) || absorb_reg;
            end else begin
                stop_now = passed_reg || (vox != ignored_reg);
            end
        end
    end

    always_comb begin
        if (tmax_reg[0] < tmax_reg[1]) begin
            ax = (tmax_reg[0] < tmax_reg[2]) ? 2'd0 : 2'd2;
        end else begin
            ax = (tmax_reg[1] < tmax_reg[2]) ? 2'd1 : 2'd2;
        end
        at_edge = neg_reg[ax] ? (cell_reg[ax] == '0)
                              : (cell_reg[ax] == CELL_W'(BRICK_SIDE - 1));
    end

    assign status.budget_done  = (steps_reg >= STEP_W'(STEP_LIMIT));
    assign status.stop         = stop_now;
    assign status.exited_brick = at_edge;

    always_comb begin
        if (!hit_reg || t_reg > $signed(TMAX_W'(33'h0_FFFF_FFFF))) begin
            dist_val = 32'hFFFF_FFFF;
        end else if (t_reg < 0) begin
            dist_val = '0;
        end else begin
            dist_val = t_reg[31:0];
        end
    end

    // Output register: loaded at the end of a trace, held until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready_in) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {steps_reg, axis_reg, dist_val,
                             hit_reg ? material_reg : 8'd0, hit_reg};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
endmodule

// ===== hw/rtl/voxel_brick_dda_traversal.sv =====
// ============================================================================
// voxel_brick_dda_traversal: DDA ray walk through one 8x8x8 voxel brick
// Loads brick bytes in order and traces rays through them.
// ============================================================================
// A load item is written into the brick memory from the idle state. A trace
// or shadow item passes through setup, then a memory read, a test and a step
// for each voxel visited, and ends in the done state, which waits until the
// output register is free. One item is worked on at a time; the finished
// result sits in an output register and the next item is taken as soon as it
// is loaded. The brick memory has a single port, read once per voxel.
module voxel_brick_dda_traversal (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tuser: action[1:0]
    input  logic [1:0]   s_tuser,
    // tdata: voxel_value[7:0], entry_x[26:8], entry_y[45:27], entry_z[64:46],
    // recip_dir_x[96:65], recip_dir_y[128:97], recip_dir_z[160:129],
    // medium_material[168:161], ignored_material[176:169],
    // random_draw[192:177], steps_before[201:193], zero fill to 207
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: hit[0], material[8:1], distance[40:9], hit_axis[42:41],
    // steps_after[51:43], zero fill to 55
    output logic [55:0]  m_tdata
);
    import vbdda_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    s_fire, m_free;
    logic [51:0] out_data;

    assign s_fire = s_tvalid && s_tready;
    assign m_free = !m_tvalid || m_tready;

    vbdda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .s_action (action_t'(s_tuser)),
        .m_free   (m_free),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready)
    );

    vbdda_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_action           (s_tuser),
        .s_voxel_value      (s_tdata[7:0]),
        .s_entry_x          (s_tdata[26:8]),
        .s_entry_y          (s_tdata[45:27]),
        .s_entry_z          (s_tdata[64:46]),
        .s_recip_dir_x      (s_tdata[96:65]),
        .s_recip_dir_y      (s_tdata[128:97]),
        .s_recip_dir_z      (s_tdata[160:129]),
        .s_medium_material  (s_tdata[168:161]),
        .s_ignored_material (s_tdata[176:169]),
        .s_random_draw      (s_tdata[192:177]),
        .s_steps_before     (s_tdata[201:193]),
        .m_ready_in         (m_tready),
        .m_valid            (m_tvalid),
        .m_data             (out_data)
    );

    assign m_tdata = {4'b0, out_data};
endmodule

// ===== hw/rtl/vbdda_checker.sv =====
// ============================================================================
// vbdda_checker: port-level checks for the voxel brick DDA traversal
// Watches the result channel and the result fields over time.
// ============================================================================
module vbdda_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata
);
    import vbdda_pkg::*;

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A miss carries material zero and saturated distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0
            && m_tdata[40:9] == 32'hFFFF_FFFF)
        else $error("miss fields wrong");

    // A load never produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("load produced a result");

    // Axis code is one of x, y, z.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[42:41] != 2'd3)
        else $error("bad axis");
endmodule

bind voxel_brick_dda_traversal vbdda_checker u_vbdda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
